>>> sv/greedy_neighbourhood_clustering_macros.svh
// ----------------------------------------------------------------------------
// Greedy neighbourhood clustering - assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_NEIGHBOURHOOD_CLUSTERING_MACROS_SVH
`define GREEDY_NEIGHBOURHOOD_CLUSTERING_MACROS_SVH

// same-cycle implication
`define GNC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GNC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/gnc_pkg.sv
// ----------------------------------------------------------------------------
// Greedy neighbourhood clustering - package
// Widths, codes and types shared by the block's modules.
// ----------------------------------------------------------------------------
package gnc_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int VCNT_W       = 5;
    localparam int THR_W        = 7;
    localparam int CFG_W        = 7;
    localparam int LIMIT_W      = THR_W + VCNT_W;
    localparam int OUT_W        = 4;

    localparam logic CFG_VERTEX_COUNT  = 1'b0;
    localparam logic CFG_THRESHOLD_PCT = 1'b1;

    localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(16);
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(70);

    typedef logic [MAX_VERTICES-1:0] row_t;
    typedef logic [VIDX_W-1:0]       vidx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [LIMIT_W-1:0]      limit_t;

    typedef enum logic [1:0] {
        FUNC_EDGE  = 2'd0,
        FUNC_RUN   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic  clear;
        logic  edge_wr;
        vidx_t a;
        vidx_t b;
    } adj_cmd_t;

endpackage

>>> sv/gnc_adj.sv
// ----------------------------------------------------------------------------
// Greedy neighbourhood clustering - adjacency matrix
// Bit matrix with self-loops; symmetric edge writes, identity clear, one read.
// ----------------------------------------------------------------------------
module gnc_adj
    import gnc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  adj_cmd_t cmd,
    input  vidx_t    rd_addr,
    output row_t     rd_row
);

    row_t rows_reg  [MAX_VERTICES];
    row_t rows_next [MAX_VERTICES];

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            rows_next[i] = rows_reg[i];
            if (cmd.clear)
            begin
                rows_next[i] = row_t'(1) << i;
            end
            else if (cmd.edge_wr)
            begin
                if (cmd.a == vidx_t'(i))
                begin
                    rows_next[i][cmd.b] = 1'b1;
                end
                if (cmd.b == vidx_t'(i))
                begin
                    rows_next[i][cmd.a] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                rows_reg[i] <= row_t'(1) << i;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                rows_reg[i] <= rows_next[i];
            end
        end
    end

    assign rd_row = rows_reg[rd_addr];

endmodule

>>> sv/gnc_match.sv
// ----------------------------------------------------------------------------
// Greedy neighbourhood clustering - match unit
// Popcount of shared neighbours and percent threshold compare for one pair.
// ----------------------------------------------------------------------------
module gnc_match
    import gnc_pkg::*;
(
    input  row_t   seed_row,
    input  row_t   cand_row,
    input  row_t   colmask,
    input  cnt_t   n,
    input  limit_t limit,
    output logic   join_ok
);

    row_t   common;
    cnt_t   shared;
    cnt_t   diff;
    limit_t diff_scaled;

    always_comb
    begin
        common = seed_row & cand_row & colmask;
        shared = '0;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            shared = shared + cnt_t'(common[i]);
        end
        diff        = n - shared;
        diff_scaled = LIMIT_W'(diff) * LIMIT_W'(100);
        join_ok     = (diff_scaled <= limit);
    end

endmodule

>>> sv/gnc_seq.sv
// ----------------------------------------------------------------------------
// Greedy neighbourhood clustering - sequencer
// Seed and candidate walk, visited marks and the one-deep result hold stage.
// ----------------------------------------------------------------------------
`include "greedy_neighbourhood_clustering_macros.svh"

module gnc_seq
    import gnc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         func,
    input  logic [VIDX_W-1:0]  vertex_a,
    input  logic [VIDX_W-1:0]  vertex_b,
    input  logic [VCNT_W-1:0]  vertex_count,
    input  logic [THR_W-1:0]   threshold_pct,
    input  row_t               rd_row,
    input  logic               join_ok,
    output adj_cmd_t           adj_cmd,
    output vidx_t              rd_addr,
    output row_t               seed_row,
    output row_t               colmask,
    output cnt_t               n,
    output limit_t             limit,
    output logic               busy,
    output logic               result_valid,
    output logic [OUT_W-1:0]   group_index,
    output logic [OUT_W-1:0]   member_vertex,
    output logic               last_in_group,
    output logic               last_of_run
);

    state_t state_reg, state_next;

    cnt_t   s_reg, s_next;
    cnt_t   j_reg, j_next;
    cnt_t   grp_reg, grp_next;
    row_t   visited_reg, visited_next;
    row_t   seed_row_reg, seed_row_next;
    cnt_t   n_reg, n_next;
    row_t   colmask_reg, colmask_next;
    limit_t limit_reg, limit_next;

    logic   pend_valid_reg, pend_valid_next;
    cnt_t   pend_grp_reg, pend_grp_next;
    vidx_t  pend_vtx_reg, pend_vtx_next;
    logic   pend_lig_reg, pend_lig_next;

    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_grp_reg, out_grp_next;
    logic [OUT_W-1:0]  out_vtx_reg, out_vtx_next;
    logic              out_lig_reg, out_lig_next;
    logic              out_lor_reg, out_lor_next;

    logic  accept;
    logic  seed_free;
    logic  cand_ok;
    logic  new_member;
    vidx_t new_vtx;
    cnt_t  n_clamp;

    assign accept    = start && (state_reg == ST_IDLE);
    assign seed_free = !visited_reg[s_reg[VIDX_W-1:0]];
    assign cand_ok   = (j_reg < n_reg) && (j_reg != s_reg)
                       && !visited_reg[j_reg[VIDX_W-1:0]] && join_ok;
    assign n_clamp   = (vertex_count > VCNT_W'(MAX_VERTICES))
                       ? cnt_t'(MAX_VERTICES) : cnt_t'(vertex_count);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == FUNC_RUN))
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                if (s_reg >= n_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (seed_free)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (j_reg >= n_reg)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        s_next          = s_reg;
        j_next          = j_reg;
        grp_next        = grp_reg;
        visited_next    = visited_reg;
        seed_row_next   = seed_row_reg;
        n_next          = n_reg;
        colmask_next    = colmask_reg;
        limit_next      = limit_reg;
        pend_valid_next = pend_valid_reg;
        pend_grp_next   = pend_grp_reg;
        pend_vtx_next   = pend_vtx_reg;
        pend_lig_next   = pend_lig_reg;
        out_valid_next  = 1'b0;
        out_grp_next    = out_grp_reg;
        out_vtx_next    = out_vtx_reg;
        out_lig_next    = out_lig_reg;
        out_lor_next    = out_lor_reg;
        new_member      = 1'b0;
        new_vtx         = '0;
        adj_cmd         = '0;
        rd_addr         = (state_reg == ST_SEED) ? s_reg[VIDX_W-1:0] : j_reg[VIDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_EDGE:
                        begin
                            adj_cmd.edge_wr = 1'b1;
                            adj_cmd.a       = vertex_a;
                            adj_cmd.b       = vertex_b;
                        end
                        FUNC_CLEAR:
                        begin
                            adj_cmd.clear = 1'b1;
                        end
                        FUNC_RUN:
                        begin
                            s_next          = '0;
                            j_next          = '0;
                            grp_next        = '0;
                            visited_next    = '0;
                            pend_valid_next = 1'b0;
                            n_next          = n_clamp;
                            colmask_next    = (n_clamp >= cnt_t'(MAX_VERTICES)) ? '1
                                              : ((row_t'(1) << n_clamp) - row_t'(1));
                            limit_next      = LIMIT_W'(threshold_pct) * LIMIT_W'(n_clamp);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEED:
            begin
                if (s_reg < n_reg)
                begin
                    if (seed_free)
                    begin
                        visited_next[s_reg[VIDX_W-1:0]] = 1'b1;
                        seed_row_next = rd_row;
                        j_next        = '0;
                        new_member    = 1'b1;
                        new_vtx       = s_reg[VIDX_W-1:0];
                    end
                    else
                    begin
                        s_next = s_reg + cnt_t'(1);
                    end
                end
            end
            ST_SCAN:
            begin
                if (j_reg < n_reg)
                begin
                    if (cand_ok)
                    begin
                        visited_next[j_reg[VIDX_W-1:0]] = 1'b1;
                        new_member = 1'b1;
                        new_vtx    = j_reg[VIDX_W-1:0];
                    end
                    j_next = j_reg + cnt_t'(1);
                end
                else
                begin
                    pend_lig_next = 1'b1;
                    grp_next      = grp_reg + cnt_t'(1);
                    s_next        = s_reg + cnt_t'(1);
                end
            end
            ST_FINISH:
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_grp_next    = pend_grp_reg[OUT_W-1:0];
                    out_vtx_next    = OUT_W'(pend_vtx_reg);
                    out_lig_next    = pend_lig_reg;
                    out_lor_next    = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        // a new member releases the held one, which is then known not to end the run
        if (new_member)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_grp_next   = pend_grp_reg[OUT_W-1:0];
                out_vtx_next   = OUT_W'(pend_vtx_reg);
                out_lig_next   = pend_lig_reg;
                out_lor_next   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_grp_next   = grp_reg;
            pend_vtx_next   = new_vtx;
            pend_lig_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            visited_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            s_reg          <= '0;
            j_reg          <= '0;
            grp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            visited_reg    <= visited_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            s_reg          <= s_next;
            j_reg          <= j_next;
            grp_reg        <= grp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_row_reg <= seed_row_next;
        n_reg        <= n_next;
        colmask_reg  <= colmask_next;
        limit_reg    <= limit_next;
        pend_grp_reg <= pend_grp_next;
        pend_vtx_reg <= pend_vtx_next;
        pend_lig_reg <= pend_lig_next;
        out_grp_reg  <= out_grp_next;
        out_vtx_reg  <= out_vtx_next;
        out_lig_reg  <= out_lig_next;
        out_lor_reg  <= out_lor_next;
    end

    assign seed_row      = seed_row_reg;
    assign colmask       = colmask_reg;
    assign n             = n_reg;
    assign limit         = limit_reg;
    assign busy          = (state_reg != ST_IDLE);
    assign result_valid  = out_valid_reg;
    assign group_index   = out_grp_reg;
    assign member_vertex = out_vtx_reg;
    assign last_in_group = out_lig_reg;
    assign last_of_run   = out_lor_reg;

    `GNC_ASSERT_NXT(a_idle_quiet, state_reg == ST_IDLE, !out_valid_reg, "item while idle")
    `GNC_ASSERT_IMP(a_lor_ends_group, out_valid_reg && out_lor_reg, out_lig_reg,
                    "end of run without end of group")
    `GNC_ASSERT_IMP(a_scan_has_seed, state_reg == ST_SCAN, pend_valid_reg,
                    "scan without a held seed")
    `GNC_ASSERT_NXT(a_run_starts, accept && (func == FUNC_RUN), state_reg == ST_SEED,
                    "run not started")

endmodule

>>> sv/greedy_neighbourhood_clustering.sv
// ----------------------------------------------------------------------------
// Greedy neighbourhood clustering - top level
// Adjacency matrix, shared match unit, sequencer and configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start/func/vertex_a/vertex_b and are taken when start is
//   high and busy is low. Edge and clear commands finish in the accepting
//   cycle; busy stays low. A run holds busy through a seed load or skip per
//   vertex, a scan of all n candidates in the popcount/compare unit per group
//   and one closing state (n = vertex_count capped at 16).
//   Each group member comes out as one item on group_index/member_vertex/
//   last_in_group/last_of_run, qualified by result_valid for one cycle; the
//   receiver must take it then. Items of a run appear in order, the last one
//   in the first cycle with busy low.
//   Registers are written through cfg_write/cfg_index/cfg_data: index 0 is
//   vertex_count, index 1 is threshold_pct. Write only while idle.
//   Reset (rst_n low, async) returns the matrix to identity, clears visited
//   marks and loads vertex_count 16, threshold_pct 70.
// ----------------------------------------------------------------------------
module greedy_neighbourhood_clustering
    import gnc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        func,
    input  logic [3:0]        vertex_a,
    input  logic [3:0]        vertex_b,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output logic              result_valid,
    output logic [3:0]        group_index,
    output logic [3:0]        member_vertex,
    output logic              last_in_group,
    output logic              last_of_run
);

    logic [VCNT_W-1:0] vertex_count_reg;
    logic [THR_W-1:0]  threshold_pct_reg;

    adj_cmd_t adj_cmd;
    vidx_t    rd_addr;
    row_t     rd_row;
    row_t     seed_row;
    row_t     colmask;
    cnt_t     n;
    limit_t   limit;
    logic     join_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg  <= VCNT_RESET;
            threshold_pct_reg <= THR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_VERTEX_COUNT:  vertex_count_reg  <= cfg_data[VCNT_W-1:0];
                CFG_THRESHOLD_PCT: threshold_pct_reg <= cfg_data[THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    gnc_adj u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (adj_cmd),
        .rd_addr (rd_addr),
        .rd_row  (rd_row)
    );

    gnc_match u_match (
        .seed_row (seed_row),
        .cand_row (rd_row),
        .colmask  (colmask),
        .n        (n),
        .limit    (limit),
        .join_ok  (join_ok)
    );

    gnc_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .func          (func),
        .vertex_a      (vertex_a),
        .vertex_b      (vertex_b),
        .vertex_count  (vertex_count_reg),
        .threshold_pct (threshold_pct_reg),
        .rd_row        (rd_row),
        .join_ok       (join_ok),
        .adj_cmd       (adj_cmd),
        .rd_addr       (rd_addr),
        .seed_row      (seed_row),
        .colmask       (colmask),
        .n             (n),
        .limit         (limit),
        .busy          (busy),
        .result_valid  (result_valid),
        .group_index   (group_index),
        .member_vertex (member_vertex),
        .last_in_group (last_in_group),
        .last_of_run   (last_of_run)
    );

endmodule
